/* sv/shl_pkg.sv */
// Shared types and constants for the sorted hit list.
// Holds the command codes and the per-cell control beat; no dependencies.
`default_nettype none

package shl_pkg;

  // Default geometry of the list
  localparam int DEPTH_DEF     = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ID_W          = 16;

  // Command codes on the kind port
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     stop_mode;  // cut every hit at or beyond the new key
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/shl_cell.sv */
// One slot of the sorted hit list chain.
// Depends on shl_pkg for the control beat; talks to its two neighbors only.
`default_nettype none

module shl_cell
  import shl_pkg::*;
#(
  parameter int KEY_W = FRAC_BITS_DEF + 1
) (
  input  wire              clk,
  input  wire              rst,
  input  cell_ctl_t        ctl,
  input  wire [KEY_W-1:0]  new_key,
  input  wire              new_line,
  input  wire [ID_W-1:0]   new_id,
  input  wire              prev_ge,
  input  wire              prev_valid,
  input  wire [KEY_W-1:0]  prev_key,
  input  wire              prev_line,
  input  wire [ID_W-1:0]   prev_id,
  input  wire              next_valid,
  input  wire [KEY_W-1:0]  next_key,
  input  wire              next_line,
  input  wire [ID_W-1:0]   next_id,
  output logic             ge,
  output logic             valid,
  output logic [KEY_W-1:0] key,
  output logic             line,
  output logic [ID_W-1:0]  id
);

  logic             valid_next;
  logic [KEY_W-1:0] key_next;
  logic             line_next;
  logic [ID_W-1:0]  id_next;

  // Flag an empty slot or a key past the new one (at or past in stop mode)
  always_comb begin
    if (!valid) begin
      ge = 1'b1;
    end else if (ctl.stop_mode) begin
      ge = (key >= new_key);
    end else begin
      ge = (key > new_key);
    end
  end

  // Pick the next slot contents from self, the new hit or a neighbor
  always_comb begin
    valid_next = valid;
    key_next   = key;
    line_next  = line;
    id_next    = id;
    case (ctl.op)
      CELL_INSERT: begin
        if (ge) begin
          if (!prev_ge) begin
            valid_next = 1'b1;
            key_next   = new_key;
            line_next  = new_line;
            id_next    = new_id;
          end else if (ctl.stop_mode) begin
            valid_next = 1'b0;
          end else begin
            valid_next = prev_valid;
            key_next   = prev_key;
            line_next  = prev_line;
            id_next    = prev_id;
          end
        end
      end
      CELL_POP: begin
        valid_next = next_valid;
        key_next   = next_key;
        line_next  = next_line;
        id_next    = next_id;
      end
      CELL_CLEAR: begin
        valid_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Hold slot state; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    key  <= key_next;
    line <= line_next;
    id   <= id_next;
  end

endmodule

`default_nettype wire

/* sv/sorted_hit_list_with_cutoff_top.sv */
// Top level of the sorted hit list: a chain of shl_cell slots plus counter.
// Depends on shl_pkg and shl_cell.
// Result: the result beat is registered and shows on done in the cycle after start is taken.
// Throughput: one command per cycle; every slot updates in parallel from its
// neighbors, so busy stays low and results cannot be stalled.
// Reset: synchronous rst empties the list and reopens it; no clearing pass.
`default_nettype none

module sorted_hit_list_with_cutoff_top
  import shl_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int KEY_W    = FRAC_BITS + 1,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int IDX_W    = $clog2(DEPTH)
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  wire [1:0]        kind,
  input  wire [KEY_W-1:0]  frac,
  input  wire              is_line,
  input  wire [ID_W-1:0]   object_id,
  input  wire              stop_here,
  output logic             done,
  output logic             got_entry,
  output logic [KEY_W-1:0] out_frac,
  output logic             out_is_line,
  output logic [ID_W-1:0]  out_object_id,
  output logic             dropped,
  output logic             ignored,
  output logic [CNT_W-1:0] held
);

  localparam logic [KEY_W-1:0] KEY_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic             closed;
  logic [KEY_W-1:0] key_sat;
  logic             stop_mode;
  logic             do_insert;
  logic             do_pop;
  logic             do_clear;
  cell_ctl_t        ctl;

  logic [DEPTH-1:0] c_ge;
  logic [DEPTH-1:0] c_valid;
  logic [DEPTH-1:0] c_line;
  logic [KEY_W-1:0] c_key [DEPTH];
  logic [ID_W-1:0]  c_id  [DEPTH];

  logic [DEPTH-1:0] cut_hot;
  logic [IDX_W-1:0] cut_idx;
  logic             lost;
  logic [CNT_W-1:0] held_next;

  assign busy = 1'b0;

  // Saturate the key and decode the command beat
  always_comb begin
    key_sat   = (frac > KEY_ONE) ? KEY_ONE : frac;
    stop_mode = stop_here && (key_sat < KEY_ONE);
    do_insert = start && (kind == KIND_INSERT) && !closed;
    do_pop    = start && (kind == KIND_POP) && (held != '0);
    do_clear  = start && (kind == KIND_CLEAR);
    ctl.stop_mode = stop_mode;
    if (do_insert) begin
      ctl.op = CELL_INSERT;
    end else if (do_pop) begin
      ctl.op = CELL_POP;
    end else if (do_clear) begin
      ctl.op = CELL_CLEAR;
    end else begin
      ctl.op = CELL_HOLD;
    end
  end

  // Chain of slots, each linked to its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             p_ge;
    logic             p_valid;
    logic [KEY_W-1:0] p_key;
    logic             p_line;
    logic [ID_W-1:0]  p_id;
    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic             n_line;
    logic [ID_W-1:0]  n_id;

    if (i == 0) begin : g_head
      assign p_ge    = 1'b0;
      assign p_valid = 1'b0;
      assign p_key   = '0;
      assign p_line  = 1'b0;
      assign p_id    = '0;
    end else begin : g_mid
      assign p_ge    = c_ge[i-1];
      assign p_valid = c_valid[i-1];
      assign p_key   = c_key[i-1];
      assign p_line  = c_line[i-1];
      assign p_id    = c_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = '0;
      assign n_line  = 1'b0;
      assign n_id    = '0;
    end else begin : g_body
      assign n_valid = c_valid[i+1];
      assign n_key   = c_key[i+1];
      assign n_line  = c_line[i+1];
      assign n_id    = c_id[i+1];
    end

    // Mark the slot where the stop hit lands
    assign cut_hot[i] = c_ge[i] && !p_ge;

    shl_cell #(
      .KEY_W (KEY_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_key    (key_sat),
      .new_line   (is_line),
      .new_id     (object_id),
      .prev_ge    (p_ge),
      .prev_valid (p_valid),
      .prev_key   (p_key),
      .prev_line  (p_line),
      .prev_id    (p_id),
      .next_valid (n_valid),
      .next_key   (n_key),
      .next_line  (n_line),
      .next_id    (n_id),
      .ge         (c_ge[i]),
      .valid      (c_valid[i]),
      .key        (c_key[i]),
      .line       (c_line[i]),
      .id         (c_id[i])
    );
  end

  // Encode the one-hot landing slot of a stop hit
  always_comb begin
    cut_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cut_hot[i]) begin
        cut_idx = cut_idx | IDX_W'(i);
      end
    end
  end

  // Work out overflow and the new hit count
  always_comb begin
    lost      = 1'b0;
    held_next = held;
    if (do_insert) begin
      if (stop_mode) begin
        lost      = !(|cut_hot);
        held_next = lost ? CNT_W'(DEPTH) : (CNT_W'(cut_idx) + CNT_W'(1));
      end else begin
        lost      = (held == CNT_W'(DEPTH));
        held_next = lost ? held : (held + CNT_W'(1));
      end
    end else if (do_pop) begin
      held_next = held - CNT_W'(1);
    end else if (do_clear) begin
      held_next = '0;
    end
  end

  // Hold list status and register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      closed <= 1'b0;
      held   <= '0;
    end else begin
      done <= start;
      held <= held_next;
      if (do_clear) begin
        closed <= 1'b0;
      end else if (do_insert && stop_mode) begin
        closed <= 1'b1;
      end
    end
    got_entry     <= do_pop;
    out_frac      <= do_pop ? c_key[0] : '0;
    out_is_line   <= do_pop ? c_line[0] : 1'b0;
    out_object_id <= do_pop ? c_id[0] : '0;
    dropped       <= lost;
    ignored       <= start && (kind == KIND_INSERT) && closed;
  end

endmodule

`default_nettype wire
